### src/keuf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keuf_pkg
// Shared constants and controller/datapath interface types for the Kruskal
// union-find core.
// ----------------------------------------------------------------------------
package keuf_pkg;

    localparam int MAX_NODES = 1024;
    localparam int VW        = $clog2(MAX_NODES);   // vertex number width
    localparam int NCW       = VW + 1;              // node count width

    typedef logic [VW-1:0]  t_vertex;
    typedef logic [NCW-1:0] t_count;

    // controller -> datapath
    typedef struct packed {
        logic clr_step;    // write identity entry, advance clear counter
        logic load_edge;   // latch endpoints, start walk on edge_from
        logic find_to;     // start walk on edge_to, keep first root
        logic find_adv;    // step walk to parent just read
        logic comp_init;   // restart at the search vertex for compression
        logic comp_rd;     // read parent of compression vertex
        logic comp_wr;     // point compression vertex at root, step on
        logic link;        // join roots if they differ
        logic out_load;    // load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;    // clear counter on last entry
        logic skip;        // new word is out of range or tree is full
        logic root_hit;    // parent read equals walk vertex
        logic comp_done;   // compression reached the root
        logic out_free;    // result register can take a word this cycle
    } t_status;

endpackage

### src/keuf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keuf_ctrl
// Sequencer for table clear, two root searches with compression, link and
// result hand-off.
// ----------------------------------------------------------------------------
module keuf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  keuf_pkg::t_status i_status,
    output keuf_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_FIND_RD  = 3'd2;
    localparam logic [2:0] ST_FIND_CHK = 3'd3;
    localparam logic [2:0] ST_COMP_RD  = 3'd4;
    localparam logic [2:0] ST_COMP_WR  = 3'd5;
    localparam logic [2:0] ST_LINK     = 3'd6;
    localparam logic [2:0] ST_OUT      = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_second, n_second;

    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        o_cmd    = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_edge = 1'b1;
                    n_second        = 1'b0;
                    n_state         = i_status.skip ? ST_OUT : ST_FIND_RD;
                end
            end
            ST_FIND_RD: begin
                // parent of the walk vertex is read on this edge
                n_state = ST_FIND_CHK;
            end
            ST_FIND_CHK: begin
                if (i_status.root_hit) begin
                    o_cmd.comp_init = 1'b1;
                    n_state         = ST_COMP_RD;
                end else begin
                    o_cmd.find_adv = 1'b1;
                    n_state        = ST_FIND_RD;
                end
            end
            ST_COMP_RD: begin
                if (i_status.comp_done) begin
                    if (r_second) begin
                        n_state = ST_LINK;
                    end else begin
                        o_cmd.find_to = 1'b1;
                        n_second      = 1'b1;
                        n_state       = ST_FIND_RD;
                    end
                end else begin
                    o_cmd.comp_rd = 1'b1;
                    n_state       = ST_COMP_WR;
                end
            end
            ST_COMP_WR: begin
                o_cmd.comp_wr = 1'b1;
                n_state       = ST_COMP_RD;
            end
            ST_LINK: begin
                o_cmd.link = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                // hold until the result register is free
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

endmodule

### src/keuf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keuf_datapath
// Parent table memory, walk registers, tree edge count, node count register
// and result register.
// ----------------------------------------------------------------------------
module keuf_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  keuf_pkg::t_count      i_cfg_data,
    input  keuf_pkg::t_vertex     i_edge_from,
    input  keuf_pkg::t_vertex     i_edge_to,
    input  logic                  i_ready,
    input  keuf_pkg::t_cmd        i_cmd,
    output keuf_pkg::t_status     o_status,
    output logic                  o_valid,
    output logic                  o_accepted,
    output keuf_pkg::t_vertex     o_tree_edge_count,
    output logic                  o_complete,
    output logic                  o_bad_vertex
);

    keuf_pkg::t_vertex r_mem [keuf_pkg::MAX_NODES];
    keuf_pkg::t_vertex r_rdata;

    keuf_pkg::t_count  r_node_count;
    keuf_pkg::t_vertex r_clr_cnt;
    keuf_pkg::t_vertex r_total;
    keuf_pkg::t_vertex r_to;
    keuf_pkg::t_vertex r_v;
    keuf_pkg::t_vertex r_r;
    keuf_pkg::t_vertex r_i;
    keuf_pkg::t_vertex r_ra;
    logic              r_bad;
    logic              r_acc;
    logic              r_out_valid;
    logic              r_out_acc;
    keuf_pkg::t_vertex r_out_count;
    logic              r_out_complete;
    logic              r_out_bad;

    keuf_pkg::t_count  node_active;
    keuf_pkg::t_count  need;
    logic              full;
    logic              bad_in;
    logic              mem_we;
    keuf_pkg::t_vertex mem_waddr;
    keuf_pkg::t_vertex mem_wdata;
    keuf_pkg::t_vertex mem_raddr;

    // clamp node count to 2..MAX_NODES
    always_comb begin
        node_active = r_node_count;
        if (r_node_count < keuf_pkg::NCW'(2)) begin
            node_active = keuf_pkg::NCW'(2);
        end else if (r_node_count > keuf_pkg::NCW'(keuf_pkg::MAX_NODES)) begin
            node_active = keuf_pkg::NCW'(keuf_pkg::MAX_NODES);
        end
    end

    assign need   = node_active - keuf_pkg::NCW'(1);
    assign full   = ({1'b0, r_total} >= need);
    assign bad_in = ({1'b0, i_edge_from} >= node_active) ||
                    ({1'b0, i_edge_to} >= node_active);

    assign o_status.clr_last  = (r_clr_cnt == keuf_pkg::VW'(keuf_pkg::MAX_NODES - 1));
    assign o_status.skip      = bad_in || full;
    assign o_status.root_hit  = (r_rdata == r_r);
    assign o_status.comp_done = (r_i == r_r);
    assign o_status.out_free  = !r_out_valid || i_ready;

    // single write port, single read port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_i;
        mem_wdata = r_r;
        if (i_cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_cnt;
            mem_wdata = r_clr_cnt;
        end else if (i_cmd.comp_wr) begin
            mem_we    = 1'b1;
            mem_waddr = r_i;
            mem_wdata = r_r;
        end else if (i_cmd.link && (r_ra != r_r)) begin
            mem_we    = 1'b1;
            mem_waddr = r_ra;
            mem_wdata = r_r;
        end
    end

    assign mem_raddr = i_cmd.comp_rd ? r_i : r_r;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // walk, compression and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_edge) begin
            r_to  <= i_edge_to;
            r_v   <= i_edge_from;
            r_r   <= i_edge_from;
            r_bad <= bad_in;
        end
        if (i_cmd.find_to) begin
            r_ra <= r_r;
            r_v  <= r_to;
            r_r  <= r_to;
        end
        if (i_cmd.find_adv) begin
            r_r <= r_rdata;
        end
        if (i_cmd.comp_init) begin
            r_i <= r_v;
        end
        if (i_cmd.comp_wr) begin
            r_i <= r_rdata;
        end
        if (i_cmd.out_load) begin
            r_out_acc      <= r_acc;
            r_out_count    <= r_total;
            r_out_complete <= full;
            r_out_bad      <= r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= keuf_pkg::NCW'(keuf_pkg::MAX_NODES);
            r_clr_cnt    <= '0;
            r_total      <= '0;
            r_acc        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + keuf_pkg::VW'(1);
            end
            if (i_cmd.load_edge) begin
                r_acc <= 1'b0;
            end
            if (i_cmd.link && (r_ra != r_r)) begin
                r_acc   <= 1'b1;
                r_total <= r_total + keuf_pkg::VW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_accepted        = r_out_acc;
    assign o_tree_edge_count = r_out_count;
    assign o_complete        = r_out_complete;
    assign o_bad_vertex      = r_out_bad;

endmodule

### src/kruskal_edge_union_find_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_edge_union_find_core
// Kruskal spanning tree builder over a union-find parent table with full
// path compression.
// ----------------------------------------------------------------------------
// After reset the core writes the identity into every entry of the parent
// table and holds o_ready low; configuration writes are taken during that
// time. Edges must arrive in weight order. The parent table has one write
// port and one read port with a registered read, so every step of a root walk
// passes through a read state and a compare state, and every compression step
// through a read state and a write-back state. An edge that is out of range,
// or one arriving after the tree is complete, skips the walks and the link and
// goes straight to the result state. The result register lets the next edge
// be accepted while the last result waits.
// ----------------------------------------------------------------------------
module kruskal_edge_union_find_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  keuf_pkg::t_count      i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  keuf_pkg::t_vertex     i_edge_from,
    input  keuf_pkg::t_vertex     i_edge_to,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_accepted,
    output keuf_pkg::t_vertex     o_tree_edge_count,
    output logic                  o_complete,
    output logic                  o_bad_vertex
);

    keuf_pkg::t_cmd    cmd;
    keuf_pkg::t_status status;

    keuf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    keuf_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_edge_from       (i_edge_from),
        .i_edge_to         (i_edge_to),
        .i_ready           (i_ready),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_valid           (o_valid),
        .o_accepted        (o_accepted),
        .o_tree_edge_count (o_tree_edge_count),
        .o_complete        (o_complete),
        .o_bad_vertex      (o_bad_vertex)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Kruskal union-find core. A local model of the
// parent table (with path compression) and the tree edge count predicts every
// result word. Edges are sent in bursts with random gaps while the result
// side stalls on its own pattern. Several vertex counts are used, the clamped
// extremes among them, and the tree is grown until it completes.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IDLE_LIMIT = 40000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic              accepted;
        keuf_pkg::t_vertex tree_edges;
        logic              complete;
        logic              bad_vertex;
    } t_tree_result;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN} t_rx_mode;
    typedef enum logic [2:0] {
        EDGE_JOIN, EDGE_IN_RANGE, EDGE_SELF, EDGE_OUT_RANGE, EDGE_NOISE
    } t_edge_kind;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    keuf_pkg::t_count  i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    keuf_pkg::t_vertex i_edge_from = '0;
    keuf_pkg::t_vertex i_edge_to = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_accepted;
    keuf_pkg::t_vertex o_tree_edge_count;
    logic              o_complete;
    logic              o_bad_vertex;

    kruskal_edge_union_find_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_edge_from       (i_edge_from),
        .i_edge_to         (i_edge_to),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_accepted        (o_accepted),
        .o_tree_edge_count (o_tree_edge_count),
        .o_complete        (o_complete),
        .o_bad_vertex      (o_bad_vertex)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Union-find model
    // ------------------------------------------------------------------
    keuf_pkg::t_vertex parent_of [keuf_pkg::MAX_NODES];
    int unsigned       tree_total = 0;
    keuf_pkg::t_count  vertex_count = keuf_pkg::t_count'(keuf_pkg::MAX_NODES);
    t_tree_result      tree_result_q [$];
    int                mismatch_count = 0;
    int                burst_left = 0;

    initial begin
        for (int i = 0; i < keuf_pkg::MAX_NODES; i++) parent_of[i] = keuf_pkg::t_vertex'(i);
    end

    function automatic int unsigned vertices_in_use();
        int unsigned n;
        n = vertex_count;
        if (n < 2) n = 2;
        if (n > keuf_pkg::MAX_NODES) n = keuf_pkg::MAX_NODES;
        return n;
    endfunction

    // Root lookup without touching the table; shapes stimulus and gives find_and_compress its root.
    function automatic keuf_pkg::t_vertex peek_root(keuf_pkg::t_vertex v);
        keuf_pkg::t_vertex r;
        r = v;
        for (int s = 0; s < keuf_pkg::MAX_NODES && parent_of[r] != r; s++) r = parent_of[r];
        return r;
    endfunction

    function automatic keuf_pkg::t_vertex find_and_compress(keuf_pkg::t_vertex v);
        keuf_pkg::t_vertex r;
        keuf_pkg::t_vertex i;
        keuf_pkg::t_vertex nxt;
        r = peek_root(v);
        i = v;
        for (int s = 0; s < keuf_pkg::MAX_NODES && i != r; s++) begin
            nxt = parent_of[i];
            parent_of[i] = r;
            i = nxt;
        end
        return r;
    endfunction

    function automatic t_tree_result apply_edge(keuf_pkg::t_vertex from_v,
                                                keuf_pkg::t_vertex to_v);
        t_tree_result      res;
        int unsigned       n;
        int unsigned       need;
        keuf_pkg::t_vertex ra;
        keuf_pkg::t_vertex rb;
        n = vertices_in_use();
        need = n - 1;
        res = '0;
        res.bad_vertex = (from_v >= n) || (to_v >= n);
        if (!res.bad_vertex && tree_total < need) begin
            ra = find_and_compress(from_v);
            rb = find_and_compress(to_v);
            if (ra != rb) begin
                parent_of[ra] = rb;
                tree_total = (tree_total + 1) & 10'h3FF;
                res.accepted = 1'b1;
            end
        end
        res.tree_edges = keuf_pkg::t_vertex'(tree_total);
        res.complete = (tree_total >= need);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    task automatic send_edge(input keuf_pkg::t_vertex from_v, input keuf_pkg::t_vertex to_v);
        int           gap;
        t_tree_result res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_edge_from = from_v;
        i_edge_to = to_v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        res = apply_edge(from_v, to_v);
        tree_result_q = {tree_result_q, res};
        burst_left--;
    endtask

    task automatic wait_drained();
        while (tree_result_q.size() != 0) @(posedge i_clk);
    endtask

    // Write the vertex count only with no word in flight.
    task automatic set_vertex_count(input keuf_pkg::t_count value);
        @(negedge i_clk);
        i_valid = 1'b0;
        wait_drained();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = value;
        vertex_count = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        burst_left = 0;
    endtask

    task automatic pick_edge(output keuf_pkg::t_vertex from_v,
                             output keuf_pkg::t_vertex to_v);
        int unsigned n;
        int          roll;
        t_edge_kind  kind;
        n = vertices_in_use();
        roll = $urandom_range(0, 99);
        if (roll < 60) kind = EDGE_JOIN;
        else if (roll < 78) kind = EDGE_IN_RANGE;
        else if (roll < 83) kind = EDGE_SELF;
        else if (roll < 93) kind = EDGE_OUT_RANGE;
        else kind = EDGE_NOISE;
        from_v = keuf_pkg::t_vertex'($urandom_range(0, n - 1));
        to_v = keuf_pkg::t_vertex'($urandom_range(0, n - 1));
        case (kind)
            EDGE_JOIN: begin
                // retry a few times to land on two separate sets
                for (int k = 0; k < 8 && peek_root(from_v) == peek_root(to_v); k++) begin
                    from_v = keuf_pkg::t_vertex'($urandom_range(0, n - 1));
                    to_v = keuf_pkg::t_vertex'($urandom_range(0, n - 1));
                end
            end
            EDGE_SELF: begin
                to_v = from_v;
            end
            EDGE_OUT_RANGE: begin
                if (n < keuf_pkg::MAX_NODES) begin
                    if ($urandom_range(0, 1) == 0)
                        from_v = keuf_pkg::t_vertex'(
                            $urandom_range(n, keuf_pkg::MAX_NODES - 1));
                    else
                        to_v = keuf_pkg::t_vertex'(
                            $urandom_range(n, keuf_pkg::MAX_NODES - 1));
                end
            end
            EDGE_NOISE: begin
                from_v = keuf_pkg::t_vertex'($urandom);
                to_v = keuf_pkg::t_vertex'($urandom);
            end
            default: begin
            end
        endcase
    endtask

    task automatic run_phase(input keuf_pkg::t_count value, input int items);
        keuf_pkg::t_vertex from_v;
        keuf_pkg::t_vertex to_v;
        set_vertex_count(value);
        for (int k = 0; k < items; k++) begin
            pick_edge(from_v, to_v);
            send_edge(from_v, to_v);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_small_tree();
        set_vertex_count(keuf_pkg::t_count'(8));
        send_edge(10'd8, 10'd0);        // bad source
        send_edge(10'd0, 10'd1023);     // bad target
        send_edge(10'd0, 10'd0);        // same set
        send_edge(10'd0, 10'd1);
        send_edge(10'd1, 10'd0);        // same set after a join
        send_edge(10'd2, 10'd3);
        send_edge(10'd1, 10'd3);        // chain 0 -> 1 -> 3
        send_edge(10'd4, 10'd5);
        send_edge(10'd6, 10'd7);
        send_edge(10'd5, 10'd7);
        send_edge(10'd0, 10'd2);        // same set, compresses 0
        send_edge(10'd0, 10'd7);        // last tree edge
        send_edge(10'd3, 10'd4);        // tree full
        send_edge(10'd1023, 10'd1023);  // tree full and bad
    endtask

    task automatic test_clamped_count();
        set_vertex_count(keuf_pkg::t_count'(0));
        send_edge(10'd0, 10'd1);
        send_edge(10'd2, 10'd0);
        set_vertex_count(keuf_pkg::t_count'(1));
        send_edge(10'd1, 10'd0);
        set_vertex_count(keuf_pkg::t_count'(2047));
        send_edge(10'd1023, 10'd0);
        send_edge(10'd1023, 10'd1023);
        send_edge(10'd512, 10'd1);
    endtask

    task automatic test_random_growth();
        run_phase(keuf_pkg::t_count'(64), 250);
        run_phase(keuf_pkg::t_count'(300), 300);
    endtask

    task automatic test_full_tree();
        run_phase(keuf_pkg::t_count'(1024), 550);
        run_phase(keuf_pkg::t_count'(2047), 350);
    endtask

    task automatic test_count_extremes();
        run_phase(keuf_pkg::t_count'(2), 60);
        run_phase(keuf_pkg::t_count'(0), 40);
        run_phase(keuf_pkg::t_count'(1), 40);
        run_phase(keuf_pkg::t_count'(1024), 60);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    t_rx_mode    rx_mode = RX_OPEN;
    int          rx_stretch = 0;
    logic [15:0] rx_pattern = 16'b1011_0011_1000_1101;

    always @(negedge i_clk) begin
        if (rx_stretch == 0) begin
            rx_stretch = $urandom_range(16, 200);
            rx_mode = t_rx_mode'($urandom_range(0, 2));
        end
        rx_stretch--;
        rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
        case (rx_mode)
            RX_OPEN:    i_ready = 1'b1;
            RX_RANDOM:  i_ready = ($urandom_range(0, 1) == 1);
            default:    i_ready = rx_pattern[0];
        endcase
    end

    always @(posedge i_clk) begin
        t_tree_result want;
        t_tree_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_accepted, o_tree_edge_count, o_complete, o_bad_vertex};
            if (tree_result_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result word: acc=%0b cnt=%0d cmp=%0b bad=%0b",
                             got.accepted, got.tree_edges, got.complete, got.bad_vertex);
            end else begin
                want = tree_result_q.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result mismatch: exp acc=%0b cnt=%0d cmp=%0b bad=%0b, %s",
                                 want.accepted, want.tree_edges, want.complete,
                                 want.bad_vertex,
                                 $sformatf("got acc=%0b cnt=%0d cmp=%0b bad=%0b",
                                           got.accepted, got.tree_edges, got.complete,
                                           got.bad_vertex));
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake on any port.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_small_tree();
        test_clamped_count();
        test_random_growth();
        test_full_tree();
        test_count_extremes();
        @(negedge i_clk);
        i_valid = 1'b0;
        wait_drained();
        // hold a little longer to catch stray result words
        repeat (32) @(posedge i_clk);
        if (mismatch_count == 0 && tree_result_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
src/keuf_pkg.sv
src/keuf_ctrl.sv
src/keuf_datapath.sv
src/kruskal_edge_union_find_core.sv
tb/tb_top.sv
